// ----- src/sorted_table_range_search_macros.svh -----
// ----------------------------------------------------------------------------
// sorted_table_range_search_macros
// assertion helpers used by the range search rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_RANGE_SEARCH_MACROS_SVH
`define SORTED_TABLE_RANGE_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define STRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define STRS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define STRS_ASSERT(lbl, prop, msg)
`define STRS_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ----- src/strs_pkg.sv -----
// ----------------------------------------------------------------------------
// strs_pkg
// types and constants for the sorted table range search
// ----------------------------------------------------------------------------
package strs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  // search bounds: low runs up to the depth, high down to -1
  localparam int BND_W       = CNT_W + 1;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 24;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FIRST = 4'b0010,
    S_LAST  = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] last;
  } result_t;

endpackage

// ----- src/strs_search.sv -----
// ----------------------------------------------------------------------------
// strs_search
// sequencer for the first and last occurrence binary searches
// ----------------------------------------------------------------------------
`include "sorted_table_range_search_macros.svh"

module strs_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [strs_pkg::DATA_W-1:0] key_i,
  input  logic [strs_pkg::CNT_W-1:0]    count_i,
  output logic                          idle_o,
  output strs_pkg::rd_req_t             rd_o,
  input  logic signed [strs_pkg::DATA_W-1:0] rd_data_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output strs_pkg::result_t             res_o
);
  import strs_pkg::*;

  state_e                    state_q, state_d;
  logic signed [BND_W-1:0]   lo_q, hi_q;
  logic [IDX_W-1:0]          mid_q;
  logic signed [DATA_W-1:0]  key_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      first_hit_q, last_hit_q;
  logic [IDX_W-1:0]          first_idx_q, last_idx_q;

  logic [CNT_W-1:0]          cnt_clamped, cnt_sel, cnt_m1;
  logic signed [BND_W-1:0]   hi_init;
  logic [IDX_W-1:0]          mid_init, mid_next;
  logic signed [BND_W-1:0]   mid_s, lo_n, hi_n;
  logic signed [BND_W:0]     bnd_sum;
  logic                      is_eq, is_lt, go_up, cont;

  assign cnt_clamped = (count_i > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_i;
  // restart of the second pass uses the stored count
  assign cnt_sel  = (state_q == S_IDLE) ? cnt_clamped : cnt_q;
  assign cnt_m1   = cnt_sel - CNT_W'(1);
  assign mid_init = cnt_m1[IDX_W:1];
  assign hi_init  = $signed({1'b0, cnt_sel}) - BND_W'(1);

  // probe result for mid_q is on rd_data_i in every search cycle
  assign mid_s = $signed({2'b00, mid_q});
  assign is_eq = (rd_data_i == key_q);
  assign is_lt = (rd_data_i < key_q);
  assign go_up = is_lt || (is_eq && (state_q == S_LAST));
  assign lo_n  = go_up ? (mid_s + BND_W'(1)) : lo_q;
  assign hi_n  = go_up ? hi_q : (mid_s - BND_W'(1));
  assign cont  = (lo_n <= hi_n);
  assign bnd_sum  = {lo_n[BND_W-1], lo_n} + {hi_n[BND_W-1], hi_n};
  assign mid_next = bnd_sum[IDX_W:1];

  always_comb begin
    rd_o.en   = 1'b0;
    rd_o.addr = mid_init;
    state_d   = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          rd_o.en = (cnt_clamped != '0);
          state_d = (cnt_clamped != '0) ? S_FIRST : S_DONE;
        end
      end
      S_FIRST: begin
        rd_o.en = 1'b1;
        if (cont) begin
          rd_o.addr = mid_next;
        end else begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        if (cont) begin
          rd_o.en   = 1'b1;
          rd_o.addr = mid_next;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      first_hit_q <= 1'b0;
      last_hit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && start_i) begin
        first_hit_q <= 1'b0;
        last_hit_q  <= 1'b0;
      end else if (state_q == S_FIRST && is_eq) begin
        first_hit_q <= 1'b1;
      end else if (state_q == S_LAST && is_eq) begin
        last_hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_o.en) begin
      mid_q <= rd_o.addr;
    end
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          key_q <= key_i;
          cnt_q <= cnt_clamped;
          lo_q  <= '0;
          hi_q  <= hi_init;
        end
      end
      S_FIRST, S_LAST: begin
        if (is_eq) begin
          if (state_q == S_FIRST) begin
            first_idx_q <= mid_q;
          end else begin
            last_idx_q <= mid_q;
          end
        end
        if (cont) begin
          lo_q <= lo_n;
          hi_q <= hi_n;
        end else begin
          lo_q <= '0;
          hi_q <= hi_init;
        end
      end
      default: begin
      end
    endcase
  end

  assign idle_o       = (state_q == S_IDLE);
  assign res_valid_o  = (state_q == S_DONE);
  assign res_o.found  = first_hit_q;
  assign res_o.first  = first_hit_q ? first_idx_q : '0;
  assign res_o.last   = last_hit_q ? last_idx_q : '0;

  `STRS_ASSERT(a_probe_in_range, (rd_o.en && state_q != S_IDLE) |-> ({1'b0, rd_o.addr} < cnt_q), "probe beyond entries in use")
  `STRS_ASSERT(a_bounds_open, (state_q == S_FIRST || state_q == S_LAST) |-> (lo_q <= hi_q), "search running on an empty range")
  `STRS_ASSERT(a_start_leaves_idle, (start_i && state_q == S_IDLE) |=> (state_q != S_IDLE), "query accepted but search not started")
  `STRS_ASSERT_NEVER(a_start_busy, start_i && state_q != S_IDLE, "query started while search busy")

endmodule

// ----- src/sorted_table_range_search.sv -----
// ----------------------------------------------------------------------------
// sorted_table_range_search
// sorted table with first and last occurrence lookup of a key
// ----------------------------------------------------------------------------
// write word: written to the table when taken, no result
// query word: one probe per cycle, up to floor(log2(count))+1 probes per search,
//   two searches back to back on the single table read port, result registered
//   in the output register after the last read returns and the search is done
// reset clears entry_count, the search state, the hit flags and the output valid; table contents stay undefined
// ----------------------------------------------------------------------------
module sorted_table_range_search (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // entry_index, entry_value, search_key, zero pad
  input  logic [strs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // req_type
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // found, first_index, last_index, zero pad
  output logic [strs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [strs_pkg::CNT_W-1:0]         cfg_data_i
);
  import strs_pkg::*;

  logic [DATA_W-1:0]        table_mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rd_data_q;

  logic [CNT_W-1:0]         entry_count_q;
  logic                     out_valid_q;
  result_t                  out_q;

  logic                     in_fire, wr_en, start;
  logic [IDX_W-1:0]         entry_index;
  logic signed [DATA_W-1:0] entry_value, search_key;
  logic                     idle;
  rd_req_t                  rd_req;
  logic                     res_valid, res_ready;
  result_t                  res;

  assign entry_index = s_axis_tdata[IDX_W-1:0];
  assign entry_value = $signed(s_axis_tdata[IDX_W+DATA_W-1:IDX_W]);
  assign search_key  = $signed(s_axis_tdata[IDX_W+2*DATA_W-1:IDX_W+DATA_W]);

  assign s_axis_tready = idle;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign wr_en         = in_fire && (s_axis_tuser == REQ_WRITE);
  assign start         = in_fire && (s_axis_tuser == REQ_QUERY);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      entry_count_q <= cfg_data_i;
    end
  end

  // table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[entry_index] <= entry_value;
    end
    if (rd_req.en) begin
      rd_data_q <= $signed(table_mem[rd_req.addr]);
    end
  end

  strs_search u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .key_i       (search_key),
    .count_i     (entry_count_q),
    .idle_o      (idle),
    .rd_o        (rd_req),
    .rd_data_i   (rd_data_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register frees the search while a result waits
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.last, out_q.first, out_q.found};

endmodule
